[sv/adx_pkg.sv]
`default_nettype none

package adx_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_RATIO     = 2'd1;
  localparam logic [1:0] CFG_ATTACK    = 2'd2;
  localparam logic [1:0] CFG_RELEASE   = 2'd3;

  // Fixed-point constants.
  localparam logic [16:0] UNITY     = 17'h10000;
  localparam logic [22:0] ENV_MAX   = 23'h7FFFFF;
  localparam logic [11:0] RATIO_ONE = 12'd256;
  localparam logic [30:0] R_ONE     = 31'h4000_0000;

  // Operations of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ENV,
    MUL_SQR,
    MUL_RATIO,
    MUL_EXP,
    MUL_OUT
  } mul_op_e;

  // Operation select and operands handed to the shared multiplier.
  typedef struct packed {
    mul_op_e            op;
    logic signed [23:0] diff;
    logic [15:0]        coef;
    logic [16:0]        mant;
    logic [20:0]        lg;
    logic [11:0]        ratio;
    logic [30:0]        root_acc;
    logic [29:0]        root;
    logic signed [15:0] smp;
    logic [16:0]        gain;
  } mul_req_t;

  // Successive square roots of one half in Q30: entry j holds 2^(-2^-(j+1)).
  // Only ever evaluated at elaboration.
  function automatic logic [15:0][29:0] exp_roots();
    logic [15:0][29:0] tab;
    logic [63:0]       k;
    logic [63:0]       v;
    logic [63:0]       res;
    logic [63:0]       bitv;
    tab = '0;
    k   = 64'h2000_0000;
    for (int i = 0; i < 16; i++) begin
      v    = k << 30;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int n = 0; n < 32; n++) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      k      = res;
      tab[i] = res[29:0];
    end
    return tab;
  endfunction

  localparam logic [15:0][29:0] EXP_ROOT = exp_roots();

  // Position of the highest set bit of a 23-bit level.
  function automatic logic [4:0] lead_one(input logic [22:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int k = 0; k < 23; k++) begin
      if (v[k]) begin
        pos = 5'(k);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

[sv/adx_mul.sv]
`default_nettype none

// Shared signed 32 x 32 multiplier with per-operation operand alignment.
module adx_mul (
  input  var adx_pkg::mul_req_t req_i,
  output logic signed [63:0]    prod_o
);

  logic signed [31:0] opa;
  logic signed [31:0] opb;

  // Extend each operation's operands to the common multiplier width.
  always_comb begin
    opa = '0;
    opb = '0;
    case (req_i.op)
      adx_pkg::MUL_ENV: begin
        opa = 32'(req_i.diff);
        opb = {16'd0, req_i.coef};
      end
      adx_pkg::MUL_SQR: begin
        opa = {15'd0, req_i.mant};
        opb = {15'd0, req_i.mant};
      end
      adx_pkg::MUL_RATIO: begin
        opa = {11'd0, req_i.lg};
        opb = {20'd0, req_i.ratio};
      end
      adx_pkg::MUL_EXP: begin
        opa = {1'b0, req_i.root_acc};
        opb = {2'd0, req_i.root};
      end
      adx_pkg::MUL_OUT: begin
        opa = 32'(req_i.smp);
        opb = {15'd0, req_i.gain};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_o = opa * opb;

endmodule

`default_nettype wire

[sv/audio_downward_expander.sv]
`default_nettype none

// Channel   Signals                                      Direction
// -------   -------------------------------------------  ---------
// input     in_valid_i/in_ready_o, channel_i, sample_in_i  in
// output    out_valid_o/out_ready_i, sample_out_o,         out
//           gain_applied_o
// config    cfg_valid_i/cfg_ready_o, cfg_index_i,          in
//           cfg_data_i
//
// A request below the threshold passes through two 16-step log2 passes and a 16-step exp2
// pass on the one shared multiplier before its result is loaded into the output register.
// Unity, zero-envelope and out-of-range-channel requests, and a gain that underflows after
// the log2 passes, go straight to the output multiply. The sequencer returns to idle before
// it takes the next request; a result held by the receiver stalls the sequencer. Reset
// clears the envelopes; configuration writes are always accepted.
module audio_downward_expander #(
  parameter int CHANNELS = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                channel_i,
  input  wire signed [15:0]  sample_in_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic [16:0]        gain_applied_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [1:0]          cfg_index_i,
  input  wire [15:0]         cfg_data_i
);

  // Only channel numbers 0 and 1 can be addressed.
  localparam int EnvDepth = (CHANNELS > 1) ? 2 : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ENV    = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_LNORM  = 4'd3;
  localparam logic [3:0] S_LSQ    = 4'd4;
  localparam logic [3:0] S_MULD   = 4'd5;
  localparam logic [3:0] S_EXP    = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_OUTMUL = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [14:0]        thr_q;
  logic [11:0]        ratio_q;
  logic [15:0]        attack_q;
  logic [15:0]        release_q;
  logic [22:0]        env_q [EnvDepth];

  logic               ch_q, ch_d;
  logic               ch_ok_q, ch_ok_d;
  logic signed [15:0] smp_q, smp_d;
  logic signed [23:0] diff_q, diff_d;
  logic [15:0]        coef_q, coef_d;
  logic [22:0]        env_cur_q, env_cur_d;
  logic [4:0]         p_q, p_d;
  logic [16:0]        m_q, m_d;
  logic [15:0]        frac_q, frac_d;
  logic               pass_q, pass_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [20:0]        lg_q, lg_d;
  logic [4:0]         q_q, q_d;
  logic [15:0]        f_q, f_d;
  logic [30:0]        r_q, r_d;
  logic [16:0]        gain_q, gain_d;
  logic               out_valid_q;
  logic signed [15:0] smp_out_q;
  logic [16:0]        gain_out_q;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               env_we;
  logic [22:0]        env_rd;
  logic [15:0]        mag;
  logic [14:0]        level;
  logic [22:0]        lvl_q8;
  logic [22:0]        tq;
  logic [11:0]        ratio_ex;
  logic signed [24:0] env_sum;
  logic [22:0]        env_new;
  logic [22:0]        norm_src;
  logic [4:0]         lead;
  logic [22:0]        norm_v;
  logic [17:0]        sq;
  logic [16:0]        m_next;
  logic [15:0]        frac_next;
  logic [20:0]        log_val;
  logic [24:0]        t_val;
  logic [30:0]        gshift;
  logic signed [63:0] mul_p;
  adx_pkg::mul_req_t  mul_req;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == S_OUTMUL) && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      ratio_q   <= 12'd256;
      attack_q  <= 16'd6554;
      release_q <= 16'd655;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adx_pkg::CFG_THRESHOLD: thr_q     <= cfg_data_i[14:0];
        adx_pkg::CFG_RATIO:     ratio_q   <= cfg_data_i[11:0];
        adx_pkg::CFG_ATTACK:    attack_q  <= cfg_data_i;
        adx_pkg::CFG_RELEASE:   release_q <= cfg_data_i;
        default:                thr_q     <= thr_q;
      endcase
    end
  end

  // Envelope read for the incoming request.
  always_comb begin
    env_rd = env_q[0];
    for (int k = 1; k < EnvDepth; k++) begin
      if (channel_i == 1'(k)) begin
        env_rd = env_q[k];
      end
    end
  end

  // Rectified and saturated level of the incoming sample.
  always_comb begin
    mag    = sample_in_i[15] ? (~sample_in_i + 16'd1) : sample_in_i;
    level  = mag[15] ? 15'h7FFF : mag[14:0];
    lvl_q8 = {level, 8'd0};
  end

  assign tq       = {thr_q, 8'd0};
  assign ratio_ex = (ratio_q > adx_pkg::RATIO_ONE) ? (ratio_q - adx_pkg::RATIO_ONE) : '0;

  // Shared multiplier: operands follow the sequencer state.
  always_comb begin
    mul_req          = '0;
    mul_req.diff     = diff_q;
    mul_req.coef     = coef_q;
    mul_req.mant     = m_q;
    mul_req.lg       = lg_q;
    mul_req.ratio    = ratio_ex;
    mul_req.root_acc = r_q;
    mul_req.root     = adx_pkg::EXP_ROOT[cnt_q];
    mul_req.smp      = smp_q;
    mul_req.gain     = gain_q;
    case (state_q)
      S_ENV:    mul_req.op = adx_pkg::MUL_ENV;
      S_LSQ:    mul_req.op = adx_pkg::MUL_SQR;
      S_MULD:   mul_req.op = adx_pkg::MUL_RATIO;
      S_EXP:    mul_req.op = adx_pkg::MUL_EXP;
      S_OUTMUL: mul_req.op = adx_pkg::MUL_OUT;
      default:  mul_req.op = adx_pkg::MUL_NONE;
    endcase
  end

  adx_mul u_mul (
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  // Envelope step: old envelope plus the floored weighted difference, clamped.
  always_comb begin
    env_sum = $signed({2'b00, env_cur_q}) + $signed(mul_p[40:16]);
    if (env_sum < 0) begin
      env_new = '0;
    end else if (env_sum > $signed({2'b00, adx_pkg::ENV_MAX})) begin
      env_new = adx_pkg::ENV_MAX;
    end else begin
      env_new = env_sum[22:0];
    end
  end

  // Normalisation of the log2 operand so that bit 16 of the mantissa is set.
  always_comb begin
    norm_src = pass_q ? env_cur_q : tq;
    lead     = adx_pkg::lead_one(norm_src);
    norm_v   = norm_src << (5'd22 - lead);
  end

  // One squaring step of the log2 fraction.
  always_comb begin
    sq        = mul_p[33:16];
    m_next    = sq[17] ? sq[17:1] : sq[16:0];
    frac_next = {frac_q[14:0], sq[17]};
    log_val   = {p_q, frac_next};
  end

  assign t_val  = mul_p[32:8];
  assign gshift = r_q >> (5'd14 + q_q);

  // Sequencer and datapath next values.
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    ch_ok_d   = ch_ok_q;
    smp_d     = smp_q;
    diff_d    = diff_q;
    coef_d    = coef_q;
    env_cur_d = env_cur_q;
    p_d       = p_q;
    m_d       = m_q;
    frac_d    = frac_q;
    pass_d    = pass_q;
    cnt_d     = cnt_q;
    lg_d      = lg_q;
    q_d       = q_q;
    f_d       = f_q;
    r_d       = r_q;
    gain_d    = gain_q;
    env_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ch_d      = channel_i;
          ch_ok_d   = 32'(channel_i) < CHANNELS;
          smp_d     = sample_in_i;
          diff_d    = $signed({1'b0, lvl_q8}) - $signed({1'b0, env_rd});
          coef_d    = (lvl_q8 > env_rd) ? attack_q : release_q;
          env_cur_d = env_rd;
          state_d   = S_ENV;
        end
      end
      S_ENV: begin
        if (!ch_ok_q) begin
          gain_d  = adx_pkg::UNITY;
          state_d = S_OUTMUL;
        end else begin
          env_we    = 1'b1;
          env_cur_d = env_new;
          state_d   = S_CHK;
        end
      end
      S_CHK: begin
        if (env_cur_q >= tq) begin
          gain_d  = adx_pkg::UNITY;
          state_d = S_OUTMUL;
        end else if (env_cur_q == '0) begin
          gain_d  = '0;
          state_d = S_OUTMUL;
        end else begin
          pass_d  = 1'b0;
          state_d = S_LNORM;
        end
      end
      S_LNORM: begin
        m_d     = norm_v[22:6];
        p_d     = lead;
        frac_d  = '0;
        cnt_d   = '0;
        state_d = S_LSQ;
      end
      S_LSQ: begin
        m_d    = m_next;
        frac_d = frac_next;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (!pass_q) begin
            lg_d    = log_val;
            pass_d  = 1'b1;
            state_d = S_LNORM;
          end else begin
            lg_d    = lg_q - log_val;
            state_d = S_MULD;
          end
        end
      end
      S_MULD: begin
        if (t_val[24:16] > 9'd16) begin
          gain_d  = '0;
          state_d = S_OUTMUL;
        end else begin
          q_d     = t_val[20:16];
          f_d     = t_val[15:0];
          r_d     = adx_pkg::R_ONE;
          cnt_d   = '0;
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        if (f_q[15]) begin
          r_d = mul_p[60:30];
        end
        f_d   = {f_q[14:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        gain_d  = (gshift > 31'(adx_pkg::UNITY)) ? adx_pkg::UNITY : gshift[16:0];
        state_d = S_OUTMUL;
      end
      S_OUTMUL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-channel envelope state.
  for (genvar k = 0; k < EnvDepth; k++) begin : g_env
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        env_q[k] <= '0;
      end else if (env_we && (ch_q == 1'(k))) begin
        env_q[k] <= env_new;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    ch_ok_q   <= ch_ok_d;
    smp_q     <= smp_d;
    diff_q    <= diff_d;
    coef_q    <= coef_d;
    env_cur_q <= env_cur_d;
    p_q       <= p_d;
    m_q       <= m_d;
    frac_q    <= frac_d;
    pass_q    <= pass_d;
    cnt_q     <= cnt_d;
    lg_q      <= lg_d;
    q_q       <= q_d;
    f_q       <= f_d;
    r_q       <= r_d;
    gain_q    <= gain_d;
  end

  // Output register: the floored product of sample and gain.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      smp_out_q  <= mul_p[31:16];
      gain_out_q <= gain_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = smp_out_q;
  assign gain_applied_o = gain_out_q;

  // The sequencer leaves idle as soon as a request is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input still ready after a request was taken");

  // Every log2 squaring step works on a normalised mantissa.
  a_mant_normalised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LSQ) |-> m_q[16])
    else $error("log2 mantissa lost its leading one");

  // The exp2 accumulator never grows above one.
  a_exp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXP) |-> (r_q <= adx_pkg::R_ONE))
    else $error("exp2 accumulator above one");

  // A delivered gain never exceeds unity.
  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_applied_o <= adx_pkg::UNITY))
    else $error("gain above unity");

  // A result is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_CHANNELS  = 2;
  localparam int IDLE_PERCENT  = 23;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 100;
  localparam int CALM_PHASE    = 3;
  localparam int HOLD_PHASE    = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int NUM_ROWS      = 34;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  // One line of the directed table: either a register write or a sample request.
  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         reg_idx;
    logic [15:0]        reg_data;
    logic               ch;
    logic signed [15:0] smp;
    logic               known;
    logic signed [15:0] known_out;
    logic [16:0]        known_gain;
  } stim_row_t;

  typedef struct packed {
    logic signed [15:0] level_out;
    logic [16:0]        gain;
  } expander_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               channel_i      = 1'b0;
  logic signed [15:0] sample_in_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic signed [15:0] sample_out_o;
  logic [16:0]        gain_applied_o;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i    = adx_pkg::CFG_THRESHOLD;
  logic [15:0]        cfg_data_i     = '0;

  // Shadow copy of the block's registers and envelopes.
  logic [14:0] thr_q     = '0;
  logic [11:0] ratio_q   = adx_pkg::RATIO_ONE;
  logic [15:0] attack_q  = 16'd6554;
  logic [15:0] release_q = 16'd655;
  logic [22:0] env_q [NUM_CHANNELS];
  logic [63:0] half_root [17];

  expander_result_t expected_results [$];
  stim_row_t        directed_rows [NUM_ROWS];

  bit calm           = 1'b0;
  int hold_req       = 0;
  int samples_sent   = 0;
  int results_checked = 0;
  int writes_done    = 0;
  int mismatch_count = 0;

  audio_downward_expander #(
    .CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_out_o  (sample_out_o),
    .gain_applied_o(gain_applied_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Integer square root by bit-wise binary search; the argument stays below 2^62.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // Base-two logarithm in Q16 by repeated squaring of the normalised mantissa.
  function automatic logic [31:0] log2_q16(input logic [23:0] v);
    int          top;
    logic [63:0] m;
    logic [15:0] frac;
    top = 0;
    for (int k = 0; k < 24; k++) begin
      if (v[k]) begin
        top = k;
      end
    end
    if (top >= 16) begin
      m = 64'(v >> (top - 16));
    end else begin
      m = 64'(v) << (16 - top);
    end
    frac = '0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 16;
      if (m >= 64'd131072) begin
        frac[i] = 1'b1;
        m       = m >> 1;
      end
    end
    return {16'(top), frac};
  endfunction

  // Gain for an envelope: (envelope / threshold)^(ratio - 1) below the threshold.
  function automatic logic [16:0] expander_gain(input logic [22:0] env);
    logic [22:0] thr_level;
    logic [31:0] excess;
    logic [31:0] dlog;
    logic [63:0] scaled;
    logic [31:0] whole;
    logic [15:0] frac;
    logic [63:0] r;
    thr_level = {thr_q, 8'd0};
    if (env >= thr_level) begin
      return adx_pkg::UNITY;
    end
    if (env == '0) begin
      return '0;
    end
    excess = (ratio_q > adx_pkg::RATIO_ONE) ? 32'(ratio_q - adx_pkg::RATIO_ONE) : 32'd0;
    dlog   = log2_q16({1'b0, thr_level}) - log2_q16({1'b0, env});
    scaled = (64'(dlog) * 64'(excess)) >> 8;
    whole  = 32'(scaled >> 16);
    if (whole > 32'd16) begin
      return '0;
    end
    frac = scaled[15:0];
    // Fractional power of two as a product of successive roots of one half.
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (frac[16-i]) begin
        r = (r * half_root[i]) >> 30;
      end
    end
    r = r >> (14 + whole);
    if (r > 64'(adx_pkg::UNITY)) begin
      r = 64'(adx_pkg::UNITY);
    end
    return r[16:0];
  endfunction

  // Envelope update for one request, then the gain and the scaled sample.
  function automatic expander_result_t predict_expander(input logic ch,
                                                        input logic signed [15:0] smp);
    longint           level;
    longint           env;
    longint           diff;
    longint           prod;
    logic [15:0]      coef;
    logic [16:0]      gain;
    expander_result_t res;
    level = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (level > 32767) begin
      level = 32767;
    end
    level = level << 8;
    env   = longint'(env_q[ch]);
    coef  = (level > env) ? attack_q : release_q;
    diff  = level - env;
    env   = env + ((diff * longint'(coef)) >>> 16);
    if (env < 0) begin
      env = 0;
    end
    if (env > longint'(adx_pkg::ENV_MAX)) begin
      env = longint'(adx_pkg::ENV_MAX);
    end
    env_q[ch] = env[22:0];
    gain      = expander_gain(env[22:0]);
    prod      = (longint'(smp) * longint'(gain)) >>> 16;
    res.level_out = prod[15:0];
    res.gain      = gain;
    return res;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_WRITE;
    row.reg_idx  = idx;
    row.reg_data = val;
    return row;
  endfunction

  function automatic stim_row_t sample_row(input logic ch, input logic signed [15:0] smp);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_SAMPLE;
    row.ch   = ch;
    row.smp  = smp;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic ch, input logic signed [15:0] smp,
                                          input logic signed [15:0] out_v,
                                          input logic [16:0] gain_v);
    stim_row_t row;
    row            = sample_row(ch, smp);
    row.known      = 1'b1;
    row.known_out  = out_v;
    row.known_gain = gain_v;
    return row;
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5:       return 16'($urandom_range(1023)) - 16'd512;
      6:          return 16'($urandom_range(8191)) - 16'd4096;
      7:          return '0;
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] random_coeff();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(2000, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample request, with a random gap first, and log its expected result.
  task automatic send_sample(input logic ch, input logic signed [15:0] smp,
                             input logic known, input expander_result_t typed);
    expander_result_t predicted;
    cfg_valid_i = 1'b0;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    channel_i   = ch;
    sample_in_i = smp;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_expander(ch, smp);
    expected_results.push_back(known ? typed : predicted);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Register write; only issued once the pipeline has drained.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      adx_pkg::CFG_THRESHOLD: thr_q     = val[14:0];
      adx_pkg::CFG_RATIO:     ratio_q   = val[11:0];
      adx_pkg::CFG_ATTACK:    attack_q  = val;
      adx_pkg::CFG_RELEASE:   release_q = val;
      default: ;
    endcase
    writes_done++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i  = 1'b0;
    cfg_valid_i = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic random_settings();
    logic [15:0] thr;
    logic [15:0] ratio;
    case ($urandom_range(5))
      0:       thr = '0;
      1:       thr = {1'($urandom), 15'h7FFF};
      2:       thr = 16'($urandom_range(300));
      default: thr = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0:       ratio = 16'($urandom_range(255));
      1:       ratio = 16'd2560;
      2:       ratio = 16'($urandom);
      default: ratio = 16'($urandom_range(2560, 256));
    endcase
    write_reg(adx_pkg::CFG_THRESHOLD, thr);
    write_reg(adx_pkg::CFG_RATIO, ratio);
    write_reg(adx_pkg::CFG_ATTACK, random_coeff());
    write_reg(adx_pkg::CFG_RELEASE, random_coeff());
  endtask

  // Receiver: random back-pressure, plus one long hold-off when requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare each delivered result with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    expander_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: sample_out %0d gain_applied %0d",
                   $signed(sample_out_o), gain_applied_o);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (sample_out_o !== want.level_out || gain_applied_o !== want.gain) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: sample_out expected %0d got %0d, gain_applied expected %0d got %0d",
                     results_checked, $signed(want.level_out), $signed(sample_out_o),
                     want.gain, gain_applied_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic prev_write;
    half_root[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      half_root[i] = floor_sqrt(half_root[i-1] << 30);
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      env_q[c] = '0;
    end

    // Directed part: unity at reset, full-swing coefficients, the ratio below one,
    // frozen envelopes and a return to a zero threshold.
    directed_rows = '{
      known_row(1'b0, 16'sd0, 16'sd0, adx_pkg::UNITY),
      known_row(1'b0, 16'sh7FFF, 16'sh7FFF, adx_pkg::UNITY),
      known_row(1'b1, 16'sh8000, 16'sh8000, adx_pkg::UNITY),
      known_row(1'b1, 16'shFFFF, 16'shFFFF, adx_pkg::UNITY),
      known_row(1'b0, 16'sd1, 16'sd1, adx_pkg::UNITY),
      reg_row(adx_pkg::CFG_THRESHOLD, 16'hFFFF),
      reg_row(adx_pkg::CFG_RATIO, 16'd2560),
      reg_row(adx_pkg::CFG_ATTACK, 16'hFFFF),
      reg_row(adx_pkg::CFG_RELEASE, 16'hFFFF),
      sample_row(1'b1, 16'sd0),
      known_row(1'b1, 16'sd0, 16'sd0, 17'd0),
      sample_row(1'b1, 16'sd3),
      sample_row(1'b0, 16'sh7FFF),
      sample_row(1'b0, 16'sh8000),
      sample_row(1'b0, 16'sd100),
      sample_row(1'b0, -16'sd7),
      reg_row(adx_pkg::CFG_RATIO, 16'd128),
      known_row(1'b0, -16'sd1234, -16'sd1234, adx_pkg::UNITY),
      reg_row(adx_pkg::CFG_RATIO, 16'hFFFF),
      reg_row(adx_pkg::CFG_ATTACK, 16'h0000),
      reg_row(adx_pkg::CFG_RELEASE, 16'h0000),
      sample_row(1'b0, 16'sd500),
      sample_row(1'b1, 16'sh8000),
      sample_row(1'b0, 16'sd0),
      reg_row(adx_pkg::CFG_RATIO, 16'd257),
      reg_row(adx_pkg::CFG_ATTACK, 16'd6554),
      reg_row(adx_pkg::CFG_RELEASE, 16'd655),
      reg_row(adx_pkg::CFG_THRESHOLD, 16'd1000),
      sample_row(1'b0, 16'sd900),
      sample_row(1'b1, -16'sd2000),
      sample_row(1'b0, 16'sd300),
      reg_row(adx_pkg::CFG_THRESHOLD, 16'h0000),
      known_row(1'b1, 16'sh8000, 16'sh8000, adx_pkg::UNITY),
      known_row(1'b0, 16'sd12345, 16'sd12345, adx_pkg::UNITY)
    };

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    prev_write = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (!prev_write) begin
          drain_results();
        end
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        prev_write = 1'b1;
      end else begin
        send_sample(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].known,
                    expander_result_t'{directed_rows[i].known_out, directed_rows[i].known_gain});
        prev_write = 1'b0;
      end
    end

    // Random part: each phase drains, picks new settings and streams requests.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      random_settings();
      calm = (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) begin
        hold_req = HOLD_CYCLES;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(1'($urandom), random_sample(), 1'b0, '0);
      end
    end
    calm = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d sample requests over %0d channels with %0d register writes;",
             samples_sent, NUM_CHANNELS, writes_done);
    $display("%0d results compared, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
